[hdl/prl_pkg.sv]
package prl_pkg;

   localparam int FRAME_W       = 16;
   localparam int PAGE_W        = 16;
   localparam int BITS_W        = 32;
   localparam int MODE_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 7;

   localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_REAR  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TOUCH     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UPDATE    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PEEK      = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOKEY = 2'd3;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  page;
      logic [BITS_W-1:0]  bits;
   } entry_type;

   // one-hot action broadcast to every cell, already gated by full/empty/hit
   typedef struct packed {
      logic      append;
      logic      pop_front;
      logic      pop_rear;
      logic      touch_move;
      logic      touch_insert;
      logic      update;
      entry_type sup;
   } cell_ctrl_type;

endpackage

[hdl/prl_cell.sv]
module prl_cell
   import prl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     key,
   input  logic          is_head,
   input  entry_type     prev_entry,
   input  logic          prev_valid,
   input  entry_type     next_entry,
   input  logic          next_valid,
   input  logic          frame_hit_before,
   input  logic          page_hit_before,
   output entry_type     entry,
   output logic          valid,
   output logic          frame_hit_after,
   output logic          page_hit_after
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      frame_match, page_match;

   assign frame_match     = valid_ff && (entry_ff.frame == key.frame);
   assign page_match      = valid_ff && (entry_ff.page == key.page);
   assign frame_hit_after = frame_hit_before | frame_match;
   assign page_hit_after  = page_hit_before | page_match;
   assign entry           = entry_ff;
   assign valid           = valid_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.append) begin
         // fill the first free slot behind the rear
         if (!valid_ff && (is_head || prev_valid)) begin
            entry_in = ctrl.sup;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_front) begin
         if (valid_ff) begin
            entry_in = next_entry;
            valid_in = next_valid;
         end
      end else if (ctrl.pop_rear) begin
         if (valid_ff && !next_valid) begin
            valid_in = 1'b0;
         end
      end else if (ctrl.touch_move) begin
         // cells up to and including the first hit slide back by one
         if (valid_ff && !frame_hit_before) begin
            entry_in = is_head ? ctrl.sup : prev_entry;
         end
      end else if (ctrl.touch_insert) begin
         entry_in = is_head ? ctrl.sup : prev_entry;
         valid_in = is_head | prev_valid;
      end else if (ctrl.update) begin
         if (page_match && !page_hit_before) begin
            entry_in = ctrl.sup;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[hdl/page_recency_list_core.sv]
// Ordered list of page entries for FIFO or LRU replacement, front at cell 0.
// Request channel (req_): tuser carries the mode, tdata the supplied entry.
// Response channel (rsp_): one response per request, in request order, with
// the returned entry (or zeros), a returned-entry flag, a status code and the
// number of entries held after the operation.
// An accepted request is held in the request register and executed once the
// response register is free or being taken; its response is registered onto rsp_.
// Throughput: one request per cycle while rsp_tready stays high. Every operation,
// including the search by frame number or page index, completes in the execute
// cycle, in which each cell of the chain compares its key and takes its new entry
// from itself, its front neighbor or its rear neighbor.
// Stall: while a response waits on rsp_tready low, one further request is held
// in the request register; req_tready drops until the response is taken.
// Reset empties the list at once (cell valid bits and count clear); there is
// no clearing pass.
module page_recency_list_core
   import prl_pkg::*;
#(
   parameter int LIST_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // frame_number[15:0], page_index[31:16], entry_bits[63:32]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_frame[15:0], out_page_index[31:16],
                                    // out_bits[63:32], entry_count[70:64], zero[71]
   output logic [2:0]  rsp_tuser    // out_valid[0], status[2:1]
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

   // request register
   logic              busy_ff, busy_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   entry_type         sup_ff, sup_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   entry_type                rsp_entry_ff, rsp_entry_in;
   logic                     rsp_flag_ff, rsp_flag_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CNT_W-1:0] count_ff, count_in;

   logic          exec;
   logic          full, empty, any_frame_hit, any_page_hit;
   cell_ctrl_type ctrl;
   entry_type     tail_entry, ret_entry;
   logic          ret_valid;
   logic [STATUS_W-1:0] status;

   entry_type             cell_entry [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] cell_valid;
   logic [LIST_DEPTH:0]   valid_ext;
   logic [LIST_DEPTH-1:0] is_tail;
   logic [LIST_DEPTH-1:0] frame_hit, page_hit;

   assign exec       = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff || exec;

   assign full          = (count_ff == CNT_FULL);
   assign empty         = !cell_valid[0];
   assign any_frame_hit = frame_hit[LIST_DEPTH-1];
   assign any_page_hit  = page_hit[LIST_DEPTH-1];
   assign valid_ext     = {1'b0, cell_valid};
   assign is_tail       = cell_valid & ~valid_ext[LIST_DEPTH:1];

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      sup_in  = sup_ff;
      if (exec) begin
         busy_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         busy_in = 1'b1;
         mode_in = req_tuser[MODE_W-1:0];
         sup_in  = '{frame: req_tdata[15:0], page: req_tdata[31:16],
                     bits: req_tdata[63:32]};
      end
   end

   // decode the held request into one cell action
   always_comb begin
      ctrl        = '0;
      ctrl.sup    = sup_ff;
      status      = STATUS_OK;
      ret_valid   = 1'b0;
      count_in    = count_ff;
      case (mode_ff)
         MODE_APPEND: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               ctrl.append = exec;
               count_in    = count_ff + 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               ctrl.pop_front = exec;
               ret_valid      = 1'b1;
               count_in       = count_ff - 1'b1;
            end
         end
         MODE_POP_REAR: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               ctrl.pop_rear = exec;
               ret_valid     = 1'b1;
               count_in      = count_ff - 1'b1;
            end
         end
         MODE_TOUCH: begin
            if (any_frame_hit) begin
               ctrl.touch_move = exec;
            end else if (full) begin
               status = STATUS_FULL;
            end else begin
               ctrl.touch_insert = exec;
               count_in          = count_ff + 1'b1;
            end
         end
         MODE_UPDATE: begin
            if (any_page_hit) begin
               ctrl.update = exec;
            end else begin
               status = STATUS_NOKEY;
            end
         end
         MODE_PEEK: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               ret_valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!exec) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      tail_entry = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         tail_entry = tail_entry | (is_tail[i] ? cell_entry[i] : '0);
      end
   end

   always_comb begin
      ret_entry = '0;
      if (ret_valid) begin
         ret_entry = (mode_ff == MODE_POP_REAR) ? tail_entry : cell_entry[0];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (exec) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = ret_entry;
         rsp_flag_in   = ret_valid;
         rsp_status_in = status;
         rsp_count_in  = ENTRY_COUNT_W'(count_in);
      end
   end

   genvar g;
   generate
      for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
         entry_type prev_entry, next_entry;
         logic      prev_valid, frame_before, page_before;
         if (g == 0) begin : g_head
            assign prev_entry   = '0;
            assign prev_valid   = 1'b0;
            assign frame_before = 1'b0;
            assign page_before  = 1'b0;
         end else begin : g_body
            assign prev_entry   = cell_entry[g-1];
            assign prev_valid   = cell_valid[g-1];
            assign frame_before = frame_hit[g-1];
            assign page_before  = page_hit[g-1];
         end
         if (g == LIST_DEPTH - 1) begin : g_rear
            assign next_entry = '0;
         end else begin : g_mid
            assign next_entry = cell_entry[g+1];
         end

         prl_cell u_cell (
            .clock            (clock),
            .reset            (reset),
            .ctrl             (ctrl),
            .key              (sup_ff),
            .is_head          (g == 0),
            .prev_entry       (prev_entry),
            .prev_valid       (prev_valid),
            .next_entry       (next_entry),
            .next_valid       (valid_ext[g+1]),
            .frame_hit_before (frame_before),
            .page_hit_before  (page_before),
            .entry            (cell_entry[g]),
            .valid            (cell_valid[g]),
            .frame_hit_after  (frame_hit[g]),
            .page_hit_after   (page_hit[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      sup_ff        <= sup_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_entry_ff.bits,
                        rsp_entry_ff.page, rsp_entry_ff.frame};
   assign rsp_tuser  = {rsp_status_ff, rsp_flag_ff};

endmodule

[tb/testbench.sv]
module testbench
   import prl_pkg::*;
();

   localparam int DEPTH            = 64;
   localparam int RANDOM_PER_PHASE = 450;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = 8;

   // modes six and seven do nothing but still answer
   localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      entry_type         ent;
   } list_request_type;

   typedef struct packed {
      entry_type                ent;
      logic                     ent_valid;
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_COUNT_W-1:0] count;
   } list_response_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   page_recency_list_core #(.LIST_DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // shadow copy of the list, front at index 0
   entry_type      list_cells [DEPTH];
   int             held = 0;

   list_request_type  pending_requests[$];
   list_response_type predicted_responses[$];

   int idle_pct   = 0;
   int stall_pct  = 0;
   int n_pushed   = 0;
   int n_accepted = 0;
   int n_checked  = 0;
   int n_mismatch = 0;
   int n_full     = 0;
   int n_empty    = 0;
   int n_nokey    = 0;
   int n_moves    = 0;
   int max_held   = 0;
   int cycles     = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic list_response_type lru_list_apply(logic [MODE_W-1:0] mode,
                                                        entry_type sup);
      list_response_type r;
      int i;
      int hit;
      r = '0;
      r.status = STATUS_OK;
      case (mode)
         MODE_APPEND: begin
            if (held >= DEPTH) r.status = STATUS_FULL;
            else begin
               list_cells[held] = sup;
               held++;
            end
         end
         MODE_POP_FRONT: begin
            if (held == 0) r.status = STATUS_EMPTY;
            else begin
               r.ent = list_cells[0];
               r.ent_valid = 1'b1;
               for (i = 0; i + 1 < held; i++) list_cells[i] = list_cells[i+1];
               held--;
            end
         end
         MODE_POP_REAR: begin
            if (held == 0) r.status = STATUS_EMPTY;
            else begin
               r.ent = list_cells[held-1];
               r.ent_valid = 1'b1;
               held--;
            end
         end
         MODE_TOUCH: begin
            hit = held;
            for (i = 0; i < held && hit == held; i++)
               if (list_cells[i].frame == sup.frame) hit = i;
            if (hit < held) begin
               // move to front: everything ahead of the hit shifts back one place
               for (i = hit; i > 0; i--) list_cells[i] = list_cells[i-1];
               list_cells[0] = sup;
               n_moves++;
            end else if (held >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = held; i > 0; i--) list_cells[i] = list_cells[i-1];
               list_cells[0] = sup;
               held++;
            end
         end
         MODE_UPDATE: begin
            hit = held;
            for (i = 0; i < held && hit == held; i++)
               if (list_cells[i].page == sup.page) hit = i;
            if (hit < held) list_cells[hit] = sup;
            else r.status = STATUS_NOKEY;
         end
         MODE_PEEK: begin
            if (held == 0) r.status = STATUS_EMPTY;
            else begin
               r.ent = list_cells[0];
               r.ent_valid = 1'b1;
            end
         end
         default: ;
      endcase
      r.count = ENTRY_COUNT_W'(held);
      if (r.status == STATUS_FULL) n_full++;
      if (r.status == STATUS_EMPTY) n_empty++;
      if (r.status == STATUS_NOKEY) n_nokey++;
      if (held > max_held) max_held = held;
      return r;
   endfunction

   task automatic add_request(logic [MODE_W-1:0] mode, logic [15:0] frame,
                              logic [15:0] page, logic [31:0] bits);
      list_request_type q;
      q.mode = mode;
      q.ent  = {frame, page, bits};
      pending_requests.push_back(q);
      n_pushed++;
   endtask

   // mostly a small key set so touch and update find their entries
   function automatic logic [15:0] pick_key();
      if ($urandom_range(99) < 70) return 16'($urandom_range(47));
      return 16'($urandom());
   endfunction

   task automatic add_random(bit grow);
      int r;
      logic [MODE_W-1:0] m;
      r = $urandom_range(99);
      if (grow) begin
         if (r < 60)      m = MODE_APPEND;
         else if (r < 85) m = MODE_TOUCH;
         else if (r < 90) m = MODE_UPDATE;
         else if (r < 94) m = MODE_PEEK;
         else if (r < 96) m = MODE_POP_FRONT;
         else if (r < 98) m = MODE_POP_REAR;
         else if (r < 99) m = MODE_RSVD6;
         else             m = MODE_RSVD7;
      end else begin
         if (r < 40)      m = MODE_POP_FRONT;
         else if (r < 80) m = MODE_POP_REAR;
         else if (r < 85) m = MODE_PEEK;
         else if (r < 90) m = MODE_UPDATE;
         else if (r < 95) m = MODE_TOUCH;
         else if (r < 98) m = MODE_APPEND;
         else if (r < 99) m = MODE_RSVD6;
         else             m = MODE_RSVD7;
      end
      add_request(m, pick_key(), pick_key(), $urandom());
   endtask

   function automatic void note_mismatch(string what, logic [31:0] want,
                                         logic [31:0] got);
      n_mismatch++;
      if (n_mismatch <= 10)
         $display("mismatch on response %0d: %s expected %h got %h",
                  n_checked, what, want, got);
   endfunction

   function automatic void check_field(string what, logic [31:0] want,
                                       logic [31:0] got);
      if (want !== got) note_mismatch(what, want, got);
   endfunction

   // request driver: advance only when the slot is free, else hold
   always @(posedge clock) begin
      list_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_responses.push_back(lru_list_apply(req_tuser,
               {req_tdata[15:0], req_tdata[31:16], req_tdata[63:32]}));
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.mode;
               req_tdata  <= {nxt.ent.bits, nxt.ent.page, nxt.ent.frame};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      list_response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_responses.size() == 0) begin
               note_mismatch("unexpected response, frame", '0, 32'(rsp_tdata[15:0]));
            end else begin
               want = predicted_responses.pop_front();
               check_field("out_frame", 32'(want.ent.frame), 32'(rsp_tdata[15:0]));
               check_field("out_page_index", 32'(want.ent.page), 32'(rsp_tdata[31:16]));
               check_field("out_bits", want.ent.bits, rsp_tdata[63:32]);
               check_field("entry_count", 32'(want.count), 32'(rsp_tdata[70:64]));
               check_field("pad bit", '0, 32'(rsp_tdata[71]));
               check_field("out_valid", 32'(want.ent_valid), 32'(rsp_tuser[0]));
               check_field("status", 32'(want.status), 32'(rsp_tuser[2:1]));
            end
            n_checked++;
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, predicted_responses.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int p;
      int seg;
      int left;
      bit grow;

      // empty list: every read and the update miss
      add_request(MODE_POP_FRONT, 16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_POP_REAR,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      add_request(MODE_PEEK,      16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_UPDATE,    16'h0005, 16'h0005, 32'h1234_5678);
      add_request(MODE_RSVD6,     16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      add_request(MODE_RSVD7,     16'h0000, 16'h0000, 32'h0000_0000);
      // field extremes, then touch insert, touch move and update hit
      add_request(MODE_APPEND,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      add_request(MODE_APPEND,    16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_TOUCH,     16'h1234, 16'h4321, 32'hDEAD_BEEF);
      add_request(MODE_PEEK,      16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_TOUCH,     16'hFFFF, 16'h0F0F, 32'hA5A5_A5A5);
      add_request(MODE_PEEK,      16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_UPDATE,    16'h00FF, 16'h0000, 32'h5A5A_5A5A);
      add_request(MODE_UPDATE,    16'h0001, 16'h7777, 32'h0000_0001);
      add_request(MODE_RSVD6,     16'hAAAA, 16'h5555, 32'hAAAA_5555);
      add_request(MODE_POP_REAR,  16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_POP_FRONT, 16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_POP_FRONT, 16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_POP_FRONT, 16'h0000, 16'h0000, 32'h0000_0000);
      add_request(MODE_POP_REAR,  16'h0000, 16'h0000, 32'h0000_0000);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         // alternate filling and draining runs so full and empty both recur
         left = RANDOM_PER_PHASE;
         grow = 1'b1;
         while (left > 0) begin
            seg = grow ? $urandom_range(80, 150) : $urandom_range(40, 110);
            for (int j = 0; j < seg && left > 0; j++) begin
               add_random(grow);
               left--;
            end
            grow = !grow;
         end
         while (pending_requests.size() > 0) @(posedge clock);
      end

      while (n_accepted < n_pushed || predicted_responses.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, %0d mismatches",
               n_accepted, n_checked, n_mismatch);
      $display("list peaked at %0d entries; full %0d, empty %0d, key miss %0d, moves %0d",
               max_held, n_full, n_empty, n_nokey, n_moves);
      if (n_mismatch == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
